@@ rtl/fir_filter_circular_delay_macros.svh @@
// Assertion shorthands for the top-level RTL file.
// Every check is sampled on clk and switched off while arst_n is low.
`ifndef FIR_FILTER_CIRCULAR_DELAY_MACROS_SVH
`define FIR_FILTER_CIRCULAR_DELAY_MACROS_SVH

// Same-cycle implication
`define FCD_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define FCD_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/fcd_pkg.sv @@
package fcd_pkg;

	// Fixed field widths
	localparam int FUNC_W      = 2;
	localparam int TAP_COUNT_W = 7;
	localparam int COEF_IDX_W  = 6;

	// Request function codes
	localparam logic [FUNC_W-1:0] FUNC_FILTER    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_LOAD_COEF = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CLEAR     = 2'd2;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLR,
		ST_MAC,
		ST_DRAIN,
		ST_ROUND,
		ST_OUT
	} fcd_state_t;

	// Control from the sequencer to the multiply-accumulate unit
	typedef struct packed {
		logic clr;
		logic vld;
	} mac_ctl_t;

endpackage

@@ rtl/fcd_if.sv @@
// Request channel: one filter, coefficient or clear request
interface fcd_req_if
	import fcd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
);
	logic                          valid;
	logic                          ready;
	logic [FUNC_W-1:0]             func;
	logic signed [SAMPLE_BITS-1:0] sample_in;
	logic [COEF_IDX_W-1:0]         coef_index;
	logic signed [COEF_BITS-1:0]   coef_value;

	modport source (output valid, func, sample_in, coef_index, coef_value, input ready);
	modport sink (input valid, func, sample_in, coef_index, coef_value, output ready);
endinterface

// Response channel: one filtered sample
interface fcd_rsp_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] sample_out;
	logic                          clipped;

	modport source (output valid, sample_out, clipped, input ready);
	modport sink (input valid, sample_out, clipped, output ready);
endinterface

// Configuration write channel: tap count
interface fcd_cfg_if
	import fcd_pkg::*;
;
	logic                   valid;
	logic                   ready;
	logic [TAP_COUNT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ rtl/fir_filter_circular_delay.sv @@
// Channel  Dir  Carries
// -------  ---  -------------------------------------------------
// req      in   func, sample_in, coef_index, coef_value
// rsp      out  sample_out, clipped
// cfg      in   data (tap count), always ready
//
// A filter request (n taps in use) reads one tap per cycle through the history
// and coefficient memories, then drains the pipeline, rounds and loads the
// output register. With zero taps a request goes straight to the output load.
// A clear or coefficient request sweeps the history memory at one entry per
// cycle. After reset both memories are swept before the first request is
// taken. A result waiting in the output register does not block the next
// request; it stalls the end of that request.
`include "fir_filter_circular_delay_macros.svh"

module fir_filter_circular_delay
	import fcd_pkg::*;
#(
	parameter int MAX_TAPS    = 64,
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	fcd_req_if.sink  req,
	fcd_rsp_if.source rsp,
	fcd_cfg_if.sink  cfg
);

	localparam int PW    = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
	localparam int CW    = (PW + 1 > TAP_COUNT_W) ? PW + 1 : TAP_COUNT_W;
	localparam int PRW   = SAMPLE_BITS + COEF_BITS;
	localparam int ACC_W = (PRW + PW > 64) ? 64 : PRW + PW;
	localparam int RW    = ACC_W - COEF_BITS + 1;

	localparam logic [PW-1:0]          LAST_ADDR = PW'(MAX_TAPS - 1);
	localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(64'sd1 <<< (COEF_BITS - 2));
	localparam logic signed [RW-1:0]    SAT_HI   = RW'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
	localparam logic signed [RW-1:0]    SAT_LO   = ~SAT_HI;

	fcd_state_t state_q, state_d;

	logic [TAP_COUNT_W-1:0] tap_count_q;
	logic [TAP_COUNT_W-1:0] n_in;
	logic [TAP_COUNT_W-1:0] n_q;
	logic [TAP_COUNT_W-1:0] tap_q;
	logic [PW-1:0]          wpos_q;
	logic [PW-1:0]          wpos_next;
	logic [PW-1:0]          idx_q;
	logic [PW-1:0]          sweep_q;
	logic                   req_fire;
	logic                   out_free;

	// Memory ports
	logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
	logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
	logic                          hist_we;
	logic [PW-1:0]                 hist_wa;
	logic signed [SAMPLE_BITS-1:0] hist_wd;
	logic                          coef_we;
	logic [PW-1:0]                 coef_wa;
	logic signed [COEF_BITS-1:0]   coef_wd;
	logic                          issue;
	logic signed [SAMPLE_BITS-1:0] hist_rd_s1;
	logic signed [COEF_BITS-1:0]   coef_rd_s1;
	logic                          vld_s1;

	// Datapath
	mac_ctl_t                      mac_ctl;
	logic                          mac_busy;
	logic signed [ACC_W-1:0]       acc;
	logic signed [ACC_W-1:0]       biased;
	logic signed [RW-1:0]          rnd_q;
	logic                          clip_hi;
	logic                          clip_lo;
	logic signed [SAMPLE_BITS-1:0] sat_val;
	logic                          out_vld_q;
	logic signed [SAMPLE_BITS-1:0] out_data_q;
	logic                          out_clip_q;

	assign req_fire  = req.valid && req.ready;
	assign out_free  = !out_vld_q || rsp.ready;
	assign cfg.ready = 1'b1;

	// Clamp the tap count to the memory depth
	assign n_in = (int'(tap_count_q) > MAX_TAPS) ? TAP_COUNT_W'(MAX_TAPS) : tap_count_q;

	// Advance the write position modulo the tap count
	assign wpos_next = (CW'(wpos_q) + CW'(1) >= CW'(n_in)) ? '0 : wpos_q + PW'(1);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT, ST_CLR: begin
				if (sweep_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (req_fire) begin
					unique case (req.func)
						FUNC_FILTER:    state_d = (n_in == '0) ? ST_OUT : ST_MAC;
						FUNC_LOAD_COEF: state_d = ST_CLR;
						FUNC_CLEAR:     state_d = ST_CLR;
						default:        state_d = ST_IDLE;
					endcase
				end
			end
			ST_MAC: begin
				if (tap_q == n_q - TAP_COUNT_W'(1)) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!vld_s1 && !mac_busy) begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_INIT;
			end
		endcase
	end

	// Outputs of the sequencer: request ready, memory writes, tap reads
	always_comb begin
		req.ready = 1'b0;
		hist_we   = 1'b0;
		hist_wa   = sweep_q;
		hist_wd   = '0;
		coef_we   = 1'b0;
		coef_wa   = sweep_q;
		coef_wd   = '0;
		issue     = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				hist_we = 1'b1;
				coef_we = 1'b1;
			end
			ST_CLR: begin
				hist_we = 1'b1;
			end
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid && req.func == FUNC_FILTER && n_in != '0) begin
					hist_we = 1'b1;
					hist_wa = wpos_q;
					hist_wd = req.sample_in;
				end
				if (req.valid && req.func == FUNC_LOAD_COEF
						&& int'(req.coef_index) < MAX_TAPS) begin
					coef_we = 1'b1;
					coef_wa = PW'(req.coef_index);
					coef_wd = req.coef_value;
				end
			end
			ST_MAC: begin
				issue = 1'b1;
			end
			ST_DRAIN, ST_ROUND, ST_OUT: begin
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			tap_count_q <= '0;
			wpos_q      <= '0;
			sweep_q     <= '0;
			n_q         <= '0;
			tap_q       <= '0;
			idx_q       <= '0;
			vld_s1      <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (cfg.valid && cfg.ready) begin
				tap_count_q <= cfg.data;
			end
			if (state_q == ST_INIT || state_q == ST_CLR) begin
				sweep_q <= sweep_q + PW'(1);
			end
			if (req_fire && req.func == FUNC_FILTER && n_in != '0) begin
				n_q    <= n_in;
				tap_q  <= '0;
				idx_q  <= wpos_q;
				wpos_q <= wpos_next;
			end
			if (req_fire && (req.func == FUNC_LOAD_COEF || req.func == FUNC_CLEAR)) begin
				wpos_q  <= '0;
				sweep_q <= '0;
			end
			// Walk the taps forward and the history backward
			if (issue) begin
				tap_q <= tap_q + TAP_COUNT_W'(1);
				idx_q <= (idx_q == '0) ? PW'(n_q - TAP_COUNT_W'(1)) : idx_q - PW'(1);
			end
		end
	end

	// History and coefficient memories, registered reads
	always_ff @(posedge clk) begin
		if (hist_we) begin
			hist_mem[hist_wa] <= hist_wd;
		end
		if (coef_we) begin
			coef_mem[coef_wa] <= coef_wd;
		end
		hist_rd_s1 <= hist_mem[idx_q];
		coef_rd_s1 <= coef_mem[PW'(tap_q)];
	end

	assign mac_ctl.clr = req_fire && req.func == FUNC_FILTER;
	assign mac_ctl.vld = vld_s1;

	fcd_mac #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.COEF_BITS  (COEF_BITS),
		.ACC_W      (ACC_W)
	) u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (mac_ctl),
		.coef  (coef_rd_s1),
		.samp  (hist_rd_s1),
		.busy  (mac_busy),
		.acc   (acc)
	);

	// Round half-up and drop the coefficient fraction bits
	assign biased = acc + RND_HALF;

	// Hold the rounded sum, or the raw sample when no taps are in use
	always_ff @(posedge clk) begin
		if (req_fire && req.func == FUNC_FILTER) begin
			rnd_q <= RW'(req.sample_in);
		end else if (state_q == ST_ROUND) begin
			rnd_q <= biased[ACC_W-1:COEF_BITS-1];
		end
	end

	// Saturate to the sample width
	assign clip_hi = rnd_q > SAT_HI;
	assign clip_lo = rnd_q < SAT_LO;
	assign sat_val = clip_hi ? SAMPLE_BITS'(SAT_HI)
		: (clip_lo ? SAMPLE_BITS'(SAT_LO) : rnd_q[SAMPLE_BITS-1:0]);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_OUT && out_free) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && out_free) begin
			out_data_q <= sat_val;
			out_clip_q <= clip_hi || clip_lo;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.sample_out = out_data_q;
	assign rsp.clipped    = out_clip_q;

	// A clear or coefficient request restarts the write position and sweeps the history
	`FCD_ASSERT_NXT(a_clear_restarts, req_fire && (req.func == FUNC_LOAD_COEF || req.func == FUNC_CLEAR), state_q == ST_CLR && wpos_q == '0, "clear request did not restart the history")

	// Rounding only starts once every product has been summed
	`FCD_ASSERT_IMP(a_round_after_drain, state_q == ST_ROUND, !vld_s1 && !mac_busy, "rounding started with products in flight")

	// The history is never written while taps are being read
	`FCD_ASSERT_IMP(a_no_write_in_mac, state_q == ST_MAC || state_q == ST_DRAIN, !hist_we && !coef_we, "memory write during accumulation")

endmodule

@@ rtl/fcd_mac.sv @@
module fcd_mac
	import fcd_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int COEF_BITS   = 16,
	parameter int ACC_W       = 38
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  mac_ctl_t                      ctl,
	input  logic signed [COEF_BITS-1:0]   coef,
	input  logic signed [SAMPLE_BITS-1:0] samp,
	output logic                          busy,
	output logic signed [ACC_W-1:0]       acc
);

	localparam int PRW = SAMPLE_BITS + COEF_BITS;

	logic                  vld_s2;
	logic signed [PRW-1:0] prod_s2;
	logic signed [ACC_W-1:0] acc_q;

	// Track the product stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= ctl.vld;
		end
	end

	// Register one product per tap
	always_ff @(posedge clk) begin
		prod_s2 <= PRW'(coef) * PRW'(samp);
	end

	// Accumulate the products, restart on a new sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl.clr) begin
			acc_q <= '0;
		end else if (vld_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	assign busy = vld_s2;
	assign acc  = acc_q;

endmodule
